[hdl/palp_pkg.sv]
// Shared types and constants for the partial annotation line parser.
// Holds the marker register map, result codes, payload structs and queue bundle.
// No dependencies.
package palp_pkg;

   // Character codes are compared on their low CHAR_BITS bits.
   localparam int CHAR_BITS  = 16;
   localparam int CHAR_WIDTH = 16;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MASK = (CHAR_BITS >= CHAR_WIDTH) ?
      {CHAR_WIDTH{1'b1}} : CHAR_WIDTH'((64'd1 << CHAR_BITS) - 64'd1);

   localparam int MAX_LEVEL_DEF   = 8;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int MAX_RES         = 3;
   localparam int CNT_BITS        = 2;

   // Configuration port.
   localparam int ADDR_BITS = 5;
   localparam int DATA_BITS = 32;
   localparam int IDX_BITS  = 3;

   localparam logic [IDX_BITS-1:0] REG_UNKNOWN     = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_SKIP        = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_NO_BOUNDARY = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_BOUNDARY    = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_TAG         = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_ALT_TAG     = 3'd5;
   localparam logic [IDX_BITS-1:0] REG_ESCAPE      = 3'd6;

   // Result kinds.
   localparam logic [2:0] KIND_WCHAR = 3'd0;
   localparam logic [2:0] KIND_LABEL = 3'd1;
   localparam logic [2:0] KIND_WEND  = 3'd2;
   localparam logic [2:0] KIND_TCHAR = 3'd3;
   localparam logic [2:0] KIND_TEND  = 3'd4;
   localparam logic [2:0] KIND_ERR   = 3'd5;

   // Boundary confidence.
   localparam logic [1:0] CONF_UNKNOWN  = 2'd0;
   localparam logic [1:0] CONF_NO       = 2'd1;
   localparam logic [1:0] CONF_BOUNDARY = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_MISPLACED = 2'd0;
   localparam logic [1:0] ERR_WORD_ESC  = 2'd1;
   localparam logic [1:0] ERR_TAG_ESC   = 2'd2;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] ch;
      logic                  line_end;
   } req_type;

   typedef struct packed {
      logic [2:0]            kind;
      logic [CHAR_WIDTH-1:0] value;
      logic [2:0]            level;
      logic [1:0]            confidence;
      logic                  certain;
      logic [1:0]            error_code;
      logic                  line_done;
      logic                  run_last;
   } rsp_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] unknown_mark;
      logic [CHAR_WIDTH-1:0] skip_mark;
      logic [CHAR_WIDTH-1:0] no_boundary_mark;
      logic [CHAR_WIDTH-1:0] boundary_mark;
      logic [CHAR_WIDTH-1:0] tag_mark;
      logic [CHAR_WIDTH-1:0] alt_tag_mark;
      logic [CHAR_WIDTH-1:0] escape_mark;
   } marks_type;

   // All results caused by one character, in order.
   typedef struct packed {
      rsp_type [MAX_RES-1:0] res;
      logic [CNT_BITS-1:0]   cnt;
   } bundle_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [5:0] {
      MODE_WSTART = 6'b000001,
      MODE_WESC   = 6'b000010,
      MODE_AFTER  = 6'b000100,
      MODE_TAG    = 6'b001000,
      MODE_TESC   = 6'b010000,
      MODE_SKIP   = 6'b100000
   } mode_type;

endpackage

[hdl/partial_annotation_line_parser_unit.sv]
// Partial annotation line parser, top level: one character code per req
// transaction, results (word and tag characters, boundary labels, word and tag
// ends, errors) as rsp transactions. Depends on palp_pkg and the palp modules.
//
// A character is taken in every cycle in which the result queue has room; the
// front end classifies it and updates the parse state in that same cycle. A
// character causes zero to three results, queued as one bundle in a queue of
// QUEUE_DEPTH bundles, and the back end delivers one result per cycle while
// the receiver is ready. A character's results pass through the queue entry,
// written at the edge that accepts it, and then the back end's output register,
// loaded once the back end has finished the bundles before it. Marker registers
// are written over the csr port at byte address 4*i and must only change while
// the block is idle.
module partial_annotation_line_parser_unit import palp_pkg::*; #(
   parameter int MAX_LEVEL   = MAX_LEVEL_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [ADDR_BITS-1:0] csr_paddr,
   input  logic [DATA_BITS-1:0] csr_pwdata,
   output logic [DATA_BITS-1:0] csr_prdata,
   output logic                 csr_pready
);

   marks_type    marks;
   q_status_type q_status;
   logic         push, pop;
   bundle_type   push_data, head;

   palp_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .marks   (marks)
   );

   palp_front #(.MAX_LEVEL(MAX_LEVEL)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .marks     (marks),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   palp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   palp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/palp_regs.sv]
// Marker character registers behind the APB-style configuration port.
// Depends on palp_pkg for the register map and the marks struct.
module palp_regs import palp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output marks_type            marks
);

   marks_type marks_ff, marks_in;
   logic [IDX_BITS-1:0] idx;
   logic [CHAR_WIDTH-1:0] rd_mark;

   assign idx    = paddr[ADDR_BITS-1:2];
   assign pready = 1'b1;
   assign marks  = marks_ff;

   always_comb begin
      marks_in = marks_ff;
      if (psel && penable && pwrite) begin
         unique case (idx)
            REG_UNKNOWN:     marks_in.unknown_mark     = pwdata[CHAR_WIDTH-1:0];
            REG_SKIP:        marks_in.skip_mark        = pwdata[CHAR_WIDTH-1:0];
            REG_NO_BOUNDARY: marks_in.no_boundary_mark = pwdata[CHAR_WIDTH-1:0];
            REG_BOUNDARY:    marks_in.boundary_mark    = pwdata[CHAR_WIDTH-1:0];
            REG_TAG:         marks_in.tag_mark         = pwdata[CHAR_WIDTH-1:0];
            REG_ALT_TAG:     marks_in.alt_tag_mark     = pwdata[CHAR_WIDTH-1:0];
            REG_ESCAPE:      marks_in.escape_mark      = pwdata[CHAR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_UNKNOWN:     rd_mark = marks_ff.unknown_mark;
         REG_SKIP:        rd_mark = marks_ff.skip_mark;
         REG_NO_BOUNDARY: rd_mark = marks_ff.no_boundary_mark;
         REG_BOUNDARY:    rd_mark = marks_ff.boundary_mark;
         REG_TAG:         rd_mark = marks_ff.tag_mark;
         REG_ALT_TAG:     rd_mark = marks_ff.alt_tag_mark;
         REG_ESCAPE:      rd_mark = marks_ff.escape_mark;
         default:         rd_mark = '0;
      endcase
      prdata = {{(DATA_BITS-CHAR_WIDTH){1'b0}}, rd_mark};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff.unknown_mark     <= 16'd32;
         marks_ff.skip_mark        <= 16'd63;
         marks_ff.no_boundary_mark <= 16'd45;
         marks_ff.boundary_mark    <= 16'd124;
         marks_ff.tag_mark         <= 16'd47;
         marks_ff.alt_tag_mark     <= 16'd38;
         marks_ff.escape_mark      <= 16'd92;
      end else begin
         marks_ff <= marks_in;
      end
   end

endmodule

[hdl/palp_front.sv]
// Front end: accepts characters, classifies them against the markers, keeps
// the parse state and builds the bundle of results for each character.
// Depends on palp_pkg.
module palp_front import palp_pkg::*; #(
   parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  marks_type    marks,
   input  q_status_type q_status,
   output logic         push,
   output bundle_type   push_data
);

   localparam int LEVEL_BITS = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;

   mode_type mode_ff, mode_in;
   logic cert_ff, cert_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic nonempty_ff, nonempty_in;

   logic accept;
   logic [CHAR_WIDTH-1:0] c;
   logic last, err;
   logic is_unk, is_no, is_bnd, is_tag, is_alt, is_esc;
   logic [2:0] lvl3;
   logic [LEVEL_BITS+2:0] lvl_wide;
   logic [CNT_BITS-1:0] n;
   bundle_type b;

   function automatic rsp_type mk(logic [2:0] kind, logic [CHAR_WIDTH-1:0] value,
                                  logic [2:0] level, logic [1:0] conf,
                                  logic cert, logic [1:0] code);
      rsp_type r;
      r.kind       = kind;
      r.value      = value;
      r.level      = level;
      r.confidence = conf;
      r.certain    = cert;
      r.error_code = code;
      r.line_done  = 1'b0;
      r.run_last   = 1'b0;
      return r;
   endfunction

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign c         = req_data.ch & CHAR_MASK;
   assign last      = req_data.line_end;
   assign lvl_wide  = {3'b000, level_ff};
   assign lvl3      = lvl_wide[2:0];

   assign is_unk = (c == (marks.unknown_mark & CHAR_MASK)) ||
                   (c == (marks.skip_mark & CHAR_MASK));
   assign is_no  = c == (marks.no_boundary_mark & CHAR_MASK);
   assign is_bnd = c == (marks.boundary_mark & CHAR_MASK);
   assign is_tag = c == (marks.tag_mark & CHAR_MASK);
   assign is_alt = c == (marks.alt_tag_mark & CHAR_MASK);
   assign is_esc = c == (marks.escape_mark & CHAR_MASK);

   always_comb begin
      mode_in     = mode_ff;
      cert_in     = cert_ff;
      level_in    = level_ff;
      nonempty_in = nonempty_ff;
      err         = 1'b0;
      n           = '0;
      b           = '0;

      unique case (mode_ff)
         MODE_WESC: begin
            b.res[n] = mk(KIND_WCHAR, c, 3'd0, CONF_UNKNOWN, 1'b0, ERR_MISPLACED);
            n = n + 2'd1;
            mode_in = MODE_AFTER;
            if (last) begin
               b.res[n] = mk(KIND_WEND, '0, 3'd0, CONF_UNKNOWN, cert_ff, ERR_MISPLACED);
               n = n + 2'd1;
            end
         end
         MODE_AFTER: begin
            if (is_tag || is_bnd) begin
               b.res[n] = mk(KIND_WEND, '0, 3'd0, CONF_UNKNOWN, cert_ff, ERR_MISPLACED);
               n = n + 2'd1;
               if (is_bnd) begin
                  b.res[n] = mk(KIND_LABEL, '0, 3'd0, CONF_BOUNDARY, 1'b0, ERR_MISPLACED);
                  n = n + 2'd1;
                  mode_in     = MODE_WSTART;
                  cert_in     = 1'b1;
                  level_in    = '0;
                  nonempty_in = 1'b0;
               end else begin
                  level_in    = '0;
                  nonempty_in = 1'b0;
                  mode_in     = MODE_TAG;
               end
            end else if (is_unk || is_no) begin
               b.res[n] = mk(KIND_LABEL, '0, 3'd0, is_unk ? CONF_UNKNOWN : CONF_NO,
                             1'b0, ERR_MISPLACED);
               n = n + 2'd1;
               if (is_unk) cert_in = 1'b0;
               mode_in = MODE_WSTART;
               if (last) begin
                  b.res[n] = mk(KIND_WEND, '0, 3'd0, CONF_UNKNOWN, cert_in, ERR_MISPLACED);
                  n = n + 2'd1;
               end
            end else begin
               b.res[n] = mk(KIND_ERR, '0, 3'd0, CONF_UNKNOWN, 1'b0, ERR_MISPLACED);
               n = n + 2'd1;
               err = 1'b1;
            end
         end
         MODE_TAG: begin
            if (is_bnd || is_tag || is_alt) begin
               // Closing a tag reports its end only if it holds characters.
               if (nonempty_ff) begin
                  b.res[n] = mk(KIND_TEND, '0, lvl3, CONF_UNKNOWN, 1'b0, ERR_MISPLACED);
                  n = n + 2'd1;
               end
               nonempty_in = 1'b0;
               if (is_bnd) begin
                  b.res[n] = mk(KIND_LABEL, '0, 3'd0, CONF_BOUNDARY, 1'b0, ERR_MISPLACED);
                  n = n + 2'd1;
                  mode_in  = MODE_WSTART;
                  cert_in  = 1'b1;
                  level_in = '0;
               end else if (is_tag) begin
                  if (level_ff != LEVEL_BITS'(MAX_LEVEL - 1)) level_in = level_ff + 1'b1;
               end
            end else if (is_esc) begin
               if (last) begin
                  b.res[n] = mk(KIND_ERR, '0, 3'd0, CONF_UNKNOWN, 1'b0, ERR_TAG_ESC);
                  n = n + 2'd1;
                  err = 1'b1;
               end else begin
                  mode_in = MODE_TESC;
               end
            end else begin
               b.res[n] = mk(KIND_TCHAR, c, lvl3, CONF_UNKNOWN, 1'b0, ERR_MISPLACED);
               n = n + 2'd1;
               nonempty_in = 1'b1;
               if (last) begin
                  b.res[n] = mk(KIND_TEND, '0, lvl3, CONF_UNKNOWN, 1'b0, ERR_MISPLACED);
                  n = n + 2'd1;
                  nonempty_in = 1'b0;
               end
            end
         end
         MODE_TESC: begin
            b.res[n] = mk(KIND_TCHAR, c, lvl3, CONF_UNKNOWN, 1'b0, ERR_MISPLACED);
            n = n + 2'd1;
            nonempty_in = 1'b1;
            mode_in     = MODE_TAG;
            if (last) begin
               b.res[n] = mk(KIND_TEND, '0, lvl3, CONF_UNKNOWN, 1'b0, ERR_MISPLACED);
               n = n + 2'd1;
               nonempty_in = 1'b0;
            end
         end
         MODE_SKIP: ;
         default: begin
            // Expecting the first character of a word.
            if (is_unk || is_no || is_bnd || is_tag || is_alt) begin
               b.res[n] = mk(KIND_ERR, '0, 3'd0, CONF_UNKNOWN, 1'b0, ERR_MISPLACED);
               n = n + 2'd1;
               err = 1'b1;
            end else if (is_esc) begin
               if (last) begin
                  b.res[n] = mk(KIND_ERR, '0, 3'd0, CONF_UNKNOWN, 1'b0, ERR_WORD_ESC);
                  n = n + 2'd1;
                  err = 1'b1;
               end else begin
                  mode_in = MODE_WESC;
               end
            end else begin
               b.res[n] = mk(KIND_WCHAR, c, 3'd0, CONF_UNKNOWN, 1'b0, ERR_MISPLACED);
               n = n + 2'd1;
               mode_in = MODE_AFTER;
               if (last) begin
                  b.res[n] = mk(KIND_WEND, '0, 3'd0, CONF_UNKNOWN, cert_ff, ERR_MISPLACED);
                  n = n + 2'd1;
               end
            end
         end
      endcase

      if (n != '0) begin
         b.res[n - 2'd1].run_last = 1'b1;
         if (last || err) b.res[n - 2'd1].line_done = 1'b1;
      end
      b.cnt = n;

      if (last) begin
         mode_in     = MODE_WSTART;
         cert_in     = 1'b1;
         level_in    = '0;
         nonempty_in = 1'b0;
      end else if (err) begin
         mode_in = MODE_SKIP;
      end
   end

   assign push      = accept && (n != '0);
   assign push_data = b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_WSTART;
         cert_ff     <= 1'b1;
         level_ff    <= '0;
         nonempty_ff <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         cert_ff     <= cert_in;
         level_ff    <= level_in;
         nonempty_ff <= nonempty_in;
      end
   end

endmodule

[hdl/palp_queue.sv]
// Short register queue of result bundles between the front and back ends.
// Depends on palp_pkg for the bundle and status types.
module palp_queue import palp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  bundle_type   push_data,
   input  logic         pop,
   output bundle_type   head,
   output q_status_type status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);

   bundle_type mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == CNT_W'(DEPTH);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue read while empty");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!push && !pop) |=> $stable(count_ff))
      else $error("queue count moved without a transaction");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

[hdl/palp_back.sv]
// Back end: hands out results of queued bundles one transaction per cycle
// on the result channel while it is ready. Depends on palp_pkg.
module palp_back import palp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  bundle_type   head,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   bundle_type cur_ff;
   logic valid_ff, valid_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic done_cur;

   assign done_cur  = valid_ff && rsp_ready && (idx_ff == cur_ff.cnt - 2'd1);
   assign pop       = !q_status.empty && (!valid_ff || done_cur);
   assign rsp_valid = valid_ff;
   assign rsp_data  = cur_ff.res[idx_ff];

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (pop) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (done_cur) begin
         valid_in = 1'b0;
         idx_in   = '0;
      end else if (valid_ff && rsp_ready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head;
   end

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < cur_ff.cnt))
      else $error("result index outside its bundle");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (idx_ff == cur_ff.cnt - 2'd1)) |-> rsp_data.run_last)
      else $error("final result of a character lacks run_last");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> (valid_ff && $stable(idx_ff)))
      else $error("stalled result moved");

endmodule

[test/partial_annotation_line_parser_unit_tb.sv]
// Self-checking testbench for partial_annotation_line_parser_unit: directed and random
// annotated lines, several marker settings, random idling and a predicting scoreboard.
// Depends on palp_pkg and the RTL of the parser.
module partial_annotation_line_parser_unit_tb;
   import palp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 60;

   localparam logic [CHAR_WIDTH-1:0] CH_A = 16'h0061;
   localparam logic [CHAR_WIDTH-1:0] CH_B = 16'h0062;
   localparam logic [CHAR_WIDTH-1:0] CH_C = 16'h0063;
   localparam logic [CHAR_WIDTH-1:0] CH_X = 16'h0078;

   // Tracks the parse state of the line and queues the results each character causes.
   class parse_tracker;
      marks_type   marks;
      mode_type    mode;
      bit          word_certain;
      int unsigned tag_level;
      bit          tag_nonempty;
      rsp_type     step_results[$];
      rsp_type     expected_results[$];
      int          errors;

      function new();
         marks.unknown_mark     = 16'd32;
         marks.skip_mark        = 16'd63;
         marks.no_boundary_mark = 16'd45;
         marks.boundary_mark    = 16'd124;
         marks.tag_mark         = 16'd47;
         marks.alt_tag_mark     = 16'd38;
         marks.escape_mark      = 16'd92;
         errors = 0;
         clear_line();
      endfunction

      function void clear_line();
         mode = MODE_WSTART;
         word_certain = 1'b1;
         tag_level = 0;
         tag_nonempty = 1'b0;
      endfunction

      function void set_mark(logic [IDX_BITS-1:0] idx, logic [CHAR_WIDTH-1:0] v);
         case (idx)
            REG_UNKNOWN:     marks.unknown_mark = v;
            REG_SKIP:        marks.skip_mark = v;
            REG_NO_BOUNDARY: marks.no_boundary_mark = v;
            REG_BOUNDARY:    marks.boundary_mark = v;
            REG_TAG:         marks.tag_mark = v;
            REG_ALT_TAG:     marks.alt_tag_mark = v;
            REG_ESCAPE:      marks.escape_mark = v;
            default: ;
         endcase
      endfunction

      function logic [CHAR_WIDTH-1:0] mark_at(logic [IDX_BITS-1:0] idx);
         case (idx)
            REG_UNKNOWN:     return marks.unknown_mark;
            REG_SKIP:        return marks.skip_mark;
            REG_NO_BOUNDARY: return marks.no_boundary_mark;
            REG_BOUNDARY:    return marks.boundary_mark;
            REG_TAG:         return marks.tag_mark;
            REG_ALT_TAG:     return marks.alt_tag_mark;
            default:         return marks.escape_mark;
         endcase
      endfunction

      function bit is_marker(logic [CHAR_WIDTH-1:0] c);
         for (int i = REG_UNKNOWN; i <= REG_ESCAPE; i++) begin
            if ((c & CHAR_MASK) == (mark_at(IDX_BITS'(i)) & CHAR_MASK)) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void emit(logic [2:0] kind, logic [CHAR_WIDTH-1:0] value, int unsigned level,
                         logic [1:0] conf, logic cert, logic [1:0] ecode);
         rsp_type r;
         if (step_results.size() >= MAX_RES) return;
         r = '0;
         r.kind = kind;
         r.value = value;
         r.level = 3'(level);
         r.confidence = conf;
         r.certain = cert;
         r.error_code = ecode;
         step_results = {step_results, r};
      endfunction

      // An empty tag closes silently.
      function void close_tag();
         if (tag_nonempty) emit(KIND_TEND, '0, tag_level, '0, 1'b0, '0);
         tag_nonempty = 1'b0;
      endfunction

      // Returns 1 unless the character falls in the skipped rest of a line.
      function bit take_char(req_type item);
         logic [CHAR_WIDTH-1:0] c;
         bit last, err, counted;
         bit is_unk, is_no, is_bnd, is_tag, is_alt, is_esc;
         rsp_type r;
         c = item.ch & CHAR_MASK;
         last = item.line_end;
         err = 1'b0;
         is_unk = c == (marks.unknown_mark & CHAR_MASK) || c == (marks.skip_mark & CHAR_MASK);
         is_no  = c == (marks.no_boundary_mark & CHAR_MASK);
         is_bnd = c == (marks.boundary_mark & CHAR_MASK);
         is_tag = c == (marks.tag_mark & CHAR_MASK);
         is_alt = c == (marks.alt_tag_mark & CHAR_MASK);
         is_esc = c == (marks.escape_mark & CHAR_MASK);
         counted = mode != MODE_SKIP;
         step_results.delete();
         case (mode)
            MODE_WESC: begin
               emit(KIND_WCHAR, c, 0, '0, 1'b0, '0);
               mode = MODE_AFTER;
               if (last) emit(KIND_WEND, '0, 0, '0, word_certain, '0);
            end
            MODE_AFTER: begin
               if (is_tag || is_bnd) begin
                  emit(KIND_WEND, '0, 0, '0, word_certain, '0);
                  if (is_bnd) begin
                     emit(KIND_LABEL, '0, 0, CONF_BOUNDARY, 1'b0, '0);
                     clear_line();
                  end else begin
                     tag_level = 0;
                     tag_nonempty = 1'b0;
                     mode = MODE_TAG;
                  end
               end else if (is_unk || is_no) begin
                  emit(KIND_LABEL, '0, 0, is_unk ? CONF_UNKNOWN : CONF_NO, 1'b0, '0);
                  if (is_unk) word_certain = 1'b0;
                  mode = MODE_WSTART;
                  if (last) emit(KIND_WEND, '0, 0, '0, word_certain, '0);
               end else begin
                  emit(KIND_ERR, '0, 0, '0, 1'b0, ERR_MISPLACED);
                  err = 1'b1;
               end
            end
            MODE_TAG: begin
               if (is_bnd) begin
                  close_tag();
                  emit(KIND_LABEL, '0, 0, CONF_BOUNDARY, 1'b0, '0);
                  clear_line();
               end else if (is_tag) begin
                  close_tag();
                  if (tag_level + 1 < MAX_LEVEL_DEF) tag_level++;
               end else if (is_alt) begin
                  close_tag();
               end else if (is_esc) begin
                  if (last) begin
                     emit(KIND_ERR, '0, 0, '0, 1'b0, ERR_TAG_ESC);
                     err = 1'b1;
                  end else begin
                     mode = MODE_TESC;
                  end
               end else begin
                  emit(KIND_TCHAR, c, tag_level, '0, 1'b0, '0);
                  tag_nonempty = 1'b1;
                  if (last) close_tag();
               end
            end
            MODE_TESC: begin
               emit(KIND_TCHAR, c, tag_level, '0, 1'b0, '0);
               tag_nonempty = 1'b1;
               mode = MODE_TAG;
               if (last) close_tag();
            end
            MODE_SKIP: ;
            default: begin
               if (is_unk || is_no || is_bnd || is_tag || is_alt) begin
                  emit(KIND_ERR, '0, 0, '0, 1'b0, ERR_MISPLACED);
                  err = 1'b1;
               end else if (is_esc) begin
                  if (last) begin
                     emit(KIND_ERR, '0, 0, '0, 1'b0, ERR_WORD_ESC);
                     err = 1'b1;
                  end else begin
                     mode = MODE_WESC;
                  end
               end else begin
                  emit(KIND_WCHAR, c, 0, '0, 1'b0, '0);
                  mode = MODE_AFTER;
                  if (last) emit(KIND_WEND, '0, 0, '0, word_certain, '0);
               end
            end
         endcase
         if (step_results.size() > 0) begin
            r = step_results.pop_back();
            r.run_last = 1'b1;
            if (last || err) r.line_done = 1'b1;
            step_results = {step_results, r};
         end
         expected_results = {expected_results, step_results};
         if (last) clear_line();
         else if (err) mode = MODE_SKIP;
         return counted;
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: kind %0d value %0h", got.kind, got.value);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         check_field("kind", want.kind, got.kind);
         check_field("value", want.value, got.value);
         check_field("level", want.level, got.level);
         check_field("confidence", want.confidence, got.confidence);
         check_field("certain", want.certain, got.certain);
         check_field("error_code", want.error_code, got.error_code);
         check_field("line_done", want.line_done, got.line_done);
         check_field("run_last", want.run_last, got.run_last);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [DATA_BITS-1:0] csr_pwdata;
   logic [DATA_BITS-1:0] csr_prdata;
   logic                 csr_pready;

   parse_tracker tracker;
   req_type      line_buf[$];
   int           req_idle_pct;
   int           rsp_stall_pct;
   int           rsp_hold;

   partial_annotation_line_parser_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // A long hold-off, when requested, overrides the random stalls.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.match_result(rsp_data);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("[partial_annotation_line_parser_unit] ERROR");
      $finish;
   end

   function automatic void push(logic [CHAR_WIDTH-1:0] c);
      req_type r;
      r.ch = c;
      r.line_end = 1'b0;
      line_buf = {line_buf, r};
   endfunction

   function automatic void end_line();
      req_type r;
      r = line_buf.pop_back();
      r.line_end = 1'b1;
      line_buf = {line_buf, r};
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] plain_char();
      logic [CHAR_WIDTH-1:0] c;
      do c = CHAR_WIDTH'($urandom_range(0, 65535)); while (tracker.is_marker(c));
      return c;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] any_char();
      if ($urandom_range(0, 1)) return tracker.mark_at(IDX_BITS'($urandom_range(REG_UNKNOWN,
                                                                             REG_ESCAPE)));
      return plain_char();
   endfunction

   function automatic void add_char();
      if ($urandom_range(0, 5) == 0) begin
         push(tracker.marks.escape_mark);
         push(any_char());
      end else begin
         push(plain_char());
      end
   endfunction

   function automatic void add_word();
      int unsigned n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         if (i > 0) push(tracker.mark_at(IDX_BITS'($urandom_range(REG_UNKNOWN, REG_NO_BOUNDARY))));
         add_char();
      end
   endfunction

   // Occasionally a long run of tag marks drives the level into saturation.
   function automatic void add_tags();
      int unsigned ntags;
      ntags = $urandom_range(1, 3);
      for (int t = 0; t < ntags; t++) begin
         if (t == 0 || $urandom_range(0, 1)) push(tracker.marks.tag_mark);
         else push(tracker.marks.alt_tag_mark);
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(6, 9)) push(tracker.marks.tag_mark);
         repeat ($urandom_range(0, 3)) add_char();
      end
   endfunction

   // Mostly well-formed lines, some with one broken spot, the rest plain noise.
   function automatic void build_line();
      int unsigned shape, nwords, pos;
      shape = $urandom_range(0, 99);
      if (shape >= 85) begin
         repeat ($urandom_range(1, 8)) push(any_char());
      end else begin
         nwords = $urandom_range(1, 3);
         for (int w = 0; w < nwords; w++) begin
            add_word();
            if ($urandom_range(0, 1)) add_tags();
            if (w < nwords - 1 || $urandom_range(0, 3) == 0) push(tracker.marks.boundary_mark);
         end
         if (shape >= 70) begin
            if ($urandom_range(0, 1)) begin
               pos = $urandom_range(0, line_buf.size() - 1);
               line_buf[pos] = req_type'{ch: any_char(), line_end: 1'b0};
            end else begin
               push(tracker.marks.escape_mark);
            end
         end
      end
      end_line();
   endfunction

   task automatic send_item(input req_type item, output bit counted);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      counted = tracker.take_char(item);
      @(negedge clock);
   endtask

   task automatic send_line(inout int accepted);
      bit counted;
      foreach (line_buf[i]) begin
         send_item(line_buf[i], counted);
         accepted += counted;
      end
      line_buf.delete();
   endtask

   task automatic random_phase(input int target);
      int accepted;
      accepted = 0;
      while (accepted < target) begin
         build_line();
         send_line(accepted);
      end
   endtask

   // Stops offering, waits for every expected result, then lets the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Transfers are issued back to back; the caller returns the bus to idle.
   task automatic csr_access(input bit wr, input logic [IDX_BITS-1:0] idx,
                             input logic [DATA_BITS-1:0] wdata,
                             output logic [DATA_BITS-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= ADDR_BITS'({idx, 2'b00});
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
   endtask

   task automatic program_mark(input logic [IDX_BITS-1:0] idx, input logic [CHAR_WIDTH-1:0] v);
      logic [DATA_BITS-1:0] rd;
      csr_access(1'b1, idx, {16'($urandom_range(0, 65535)), v}, rd);
      tracker.set_mark(idx, v);
      csr_access(1'b0, idx, '0, rd);
      if (rd[CHAR_WIDTH-1:0] != v) begin
         $error("mark register %0d mismatch: expected %0h, actual %0h", idx, v,
                rd[CHAR_WIDTH-1:0]);
         tracker.errors++;
      end
   endtask

   task automatic load_marks(input marks_type m);
      program_mark(REG_UNKNOWN, m.unknown_mark);
      program_mark(REG_SKIP, m.skip_mark);
      program_mark(REG_NO_BOUNDARY, m.no_boundary_mark);
      program_mark(REG_BOUNDARY, m.boundary_mark);
      program_mark(REG_TAG, m.tag_mark);
      program_mark(REG_ALT_TAG, m.alt_tag_mark);
      program_mark(REG_ESCAPE, m.escape_mark);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Hand-built lines for the reset marks.
   task automatic directed_lines();
      marks_type m;
      int accepted;
      m = tracker.marks;
      accepted = 0;
      // Extreme codes, every label, tag ends by alternative and by boundary, escapes.
      push('0);
      push(m.unknown_mark);
      push(16'hFFFF);
      push(m.skip_mark);
      push(CH_C);
      push(m.tag_mark);
      push(CH_X);
      push(m.alt_tag_mark);
      push(m.escape_mark);
      push(m.tag_mark);
      push(m.boundary_mark);
      push(m.escape_mark);
      push(m.boundary_mark);
      push(m.no_boundary_mark);
      push(CH_B);
      end_line();
      send_line(accepted);
      // A misplaced marker up front; the rest of the line is skipped.
      push(m.no_boundary_mark);
      push(CH_A);
      end_line();
      send_line(accepted);
      // Dangling escape at a word start, then in a tag.
      push(m.escape_mark);
      end_line();
      send_line(accepted);
      push(CH_A);
      push(m.tag_mark);
      push(m.escape_mark);
      end_line();
      send_line(accepted);
      // The line ends on a tag mark after an empty tag, which gives no result.
      push(CH_A);
      push(m.tag_mark);
      push(m.tag_mark);
      end_line();
      send_line(accepted);
      // Two word characters with no mark between them.
      push(CH_A);
      push(CH_B);
      end_line();
      send_line(accepted);
   endtask

   initial begin
      marks_type m;
      tracker = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_idle_pct = 26;
      rsp_stall_pct = 80;
      rsp_hold = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_lines();
      wait_idle();

      m = tracker.marks;
      load_marks(m);
      // The receiver holds off while the sender keeps offering, so the block backs up.
      rsp_hold = HOLD_CYCLES;
      random_phase(90);
      wait_idle();

      m = '{unknown_mark: 16'h0000, skip_mark: 16'hFFFF, no_boundary_mark: 16'h0001,
            boundary_mark: 16'hFFFE, tag_mark: 16'h8000, alt_tag_mark: 16'h7FFF,
            escape_mark: 16'hFFFD};
      load_marks(m);
      random_phase(90);
      wait_idle();

      req_idle_pct = 80;
      rsp_stall_pct = 26;
      // Shared codes exercise the marker priorities.
      m = '{unknown_mark: 16'h0041, skip_mark: 16'h0041, no_boundary_mark: 16'h0042,
            boundary_mark: 16'h0042, tag_mark: 16'h0043, alt_tag_mark: 16'h0043,
            escape_mark: 16'h0043};
      load_marks(m);
      random_phase(85);
      wait_idle();

      m.unknown_mark = 16'($urandom_range(0, 65535));
      m.skip_mark = 16'($urandom_range(0, 65535));
      m.no_boundary_mark = 16'($urandom_range(0, 65535));
      m.boundary_mark = 16'($urandom_range(0, 65535));
      m.tag_mark = 16'($urandom_range(0, 65535));
      m.alt_tag_mark = 16'($urandom_range(0, 65535));
      m.escape_mark = 16'($urandom_range(0, 65535));
      load_marks(m);
      random_phase(45);
      wait_idle();
      random_phase(45);
      wait_idle();

      req_idle_pct = 0;
      rsp_stall_pct = 0;
      m.unknown_mark = 16'($urandom_range(0, 7));
      m.skip_mark = 16'($urandom_range(0, 7));
      m.no_boundary_mark = 16'($urandom_range(0, 7));
      m.boundary_mark = 16'($urandom_range(0, 7));
      m.tag_mark = 16'($urandom_range(0, 7));
      m.alt_tag_mark = 16'($urandom_range(0, 7));
      m.escape_mark = 16'($urandom_range(0, 7));
      load_marks(m);
      random_phase(90);
      wait_idle();

      if (tracker.errors == 0) begin
         $display("[partial_annotation_line_parser_unit] OK");
      end else begin
         $display("[partial_annotation_line_parser_unit] ERROR");
      end
      $finish;
   end

endmodule
